// File: src/gss_pkg.sv
// Shared types and constants for the gesture sector selector.
package gss_pkg;

   typedef logic [2:0] sector_type;

   localparam sector_type ZONE_CENTER = 3'd0;
   localparam sector_type ZONE_UP     = 3'd1;
   localparam sector_type ZONE_DOWN   = 3'd2;
   localparam sector_type ZONE_LEFT   = 3'd3;
   localparam sector_type ZONE_RIGHT  = 3'd4;

   localparam logic [1:0]  GRACE_TICKS          = 2'd3;
   localparam logic [15:0] PICK_THRESHOLD_RESET = 16'd28;

   localparam int REQ_W = 184;
   localparam int RSP_W = 16;

   // Result fields, is_open in bit 0.
   typedef struct packed {
      logic       equip_window;
      sector_type execute_sector;
      logic       execute;
      logic       changed_pulse;
      logic       opened_pulse;
      sector_type sector;
      logic       is_open;
   } rsp_fields_type;

endpackage

// File: src/gesture_sector_selector.sv
// Gesture sector selector: one result beat per request beat, shared-multiplier sequencer.
// An open, available, valid-pose beat steps from accept through S_MX, S_MZ, S_MT, S_LAT,
// S_ML, S_MV and S_R2 to S_DONE; other beats go straight to S_DONE, which waits on a stalled
// output. A new request is taken only in S_IDLE. One 29x29 multiplier does the five products
// in turn (two projections, threshold, two squares).
// Reset (synchronous, active high) closes the selector, clears anchor, axis and grace
// counter and loads the pick threshold with 28.
module gesture_sector_selector
   import gss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // select_held, available, pose_valid, hand_x, hand_y, hand_z, body_x, body_y,
   // body_z, right_x, right_z; zero pad at the top
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // is_open, sector[2:0], opened_pulse, changed_pulse, execute, execute_sector[2:0],
   // equip_window; zero pad at the top
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_MX, S_MZ, S_MT, S_LAT, S_ML, S_MV, S_R2, S_DONE
   } state_type;

   state_type      state_ff;
   logic [15:0]    thresh_ff;
   logic           open_ff;
   sector_type     sector_ff;
   logic signed [24:0] anchor_ff [3];
   logic signed [15:0] right_ff  [2];
   logic [1:0]     grace_ff;
   logic           rsp_valid_ff;
   rsp_fields_type rsp_ff;

   // captured request beat
   logic           held_ff, avail_ff, pose_ff;
   logic signed [24:0] off_ff [3];
   logic signed [25:0] d_ff   [3];
   logic signed [15:0] rin_ff [2];

   logic signed [57:0] prod_ff;
   logic signed [42:0] acc_ff;
   logic signed [28:0] lat_ff;
   logic [31:0]    th2_ff;
   logic [54:0]    r2_ff;

   // request fields
   logic           req_held, req_avail, req_pose;
   logic signed [23:0] req_hand [3];
   logic signed [23:0] req_body [3];
   logic signed [15:0] req_right [2];

   assign req_held     = req_tdata[0];
   assign req_avail    = req_tdata[1];
   assign req_pose     = req_tdata[2];
   assign req_hand[0]  = req_tdata[26:3];
   assign req_hand[1]  = req_tdata[50:27];
   assign req_hand[2]  = req_tdata[74:51];
   assign req_body[0]  = req_tdata[98:75];
   assign req_body[1]  = req_tdata[122:99];
   assign req_body[2]  = req_tdata[146:123];
   assign req_right[0] = req_tdata[162:147];
   assign req_right[1] = req_tdata[178:163];

   logic req_fire;
   logic out_free;
   logic rsp_valid_in;
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = ((state_ff == S_DONE) && out_free) || (rsp_valid_ff && !rsp_tready);
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(RSP_W - $bits(rsp_fields_type)){1'b0}}, rsp_ff};

   // hand offset from body, and displacement from the anchor
   logic signed [24:0] off_in [3];
   logic signed [25:0] d_in   [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_in[i] = 25'(req_hand[i]) - 25'(req_body[i]);
         d_in[i]   = 26'(off_in[i]) - 26'(anchor_ff[i]);
      end
   end

   // shared multiplier
   logic signed [28:0] mul_a, mul_b;
   logic signed [57:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MX: begin
            mul_a = 29'(d_ff[0]);
            mul_b = 29'(right_ff[0]);
         end
         S_MZ: begin
            mul_a = 29'(d_ff[2]);
            mul_b = 29'(right_ff[1]);
         end
         S_MT: begin
            mul_a = {13'b0, thresh_ff};
            mul_b = {13'b0, thresh_ff};
         end
         S_ML: begin
            mul_a = lat_ff;
            mul_b = lat_ff;
         end
         S_MV: begin
            mul_a = 29'(d_ff[1]);
            mul_b = 29'(d_ff[1]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // divide by 2^14 rounding toward zero
   logic signed [42:0] acc_bias;
   logic signed [28:0] lat_in;
   assign acc_bias = acc_ff + {29'b0, {14{acc_ff[42]}}};
   assign lat_in   = acc_bias[42:14];

   // sector pick
   logic signed [28:0] lat_neg;
   logic [27:0]    abs_lat;
   logic [27:0]    abs_vert;
   logic           lat_pos, vert_pos;
   sector_type     lat_sec, vert_sec;
   logic [63:0]    r2_x400;
   logic [63:0]    th2_x169;
   logic [27:0]    cur_mag, oth_mag;
   logic [32:0]    oth_x20, cur_x23;
   logic           cur_is_lat;
   sector_type     pick;

   always_comb begin
      lat_neg   = -lat_ff;
      abs_lat   = lat_ff[28] ? lat_neg[27:0] : lat_ff[27:0];
      abs_vert  = d_ff[1][25] ? 28'(-d_ff[1]) : 28'(d_ff[1]);
      lat_pos   = !lat_ff[28] && (lat_ff != '0);
      vert_pos  = !d_ff[1][25] && (d_ff[1] != '0);
      lat_sec   = lat_pos ? ZONE_RIGHT : ZONE_LEFT;
      vert_sec  = vert_pos ? ZONE_UP : ZONE_DOWN;
      r2_x400   = ({9'b0, r2_ff} << 8) + ({9'b0, r2_ff} << 7) + ({9'b0, r2_ff} << 4);
      th2_x169  = ({32'b0, th2_ff} << 7) + ({32'b0, th2_ff} << 5) + ({32'b0, th2_ff} << 3)
                  + {32'b0, th2_ff};
      cur_is_lat = (sector_ff == ZONE_LEFT) || (sector_ff == ZONE_RIGHT);
      cur_mag   = cur_is_lat ? abs_lat : abs_vert;
      oth_mag   = cur_is_lat ? abs_vert : abs_lat;
      oth_x20   = ({5'b0, oth_mag} << 4) + ({5'b0, oth_mag} << 2);
      cur_x23   = ({5'b0, cur_mag} << 4) + ({5'b0, cur_mag} << 2)
                  + ({5'b0, cur_mag} << 1) + {5'b0, cur_mag};
      pick      = sector_ff;
      if (sector_ff == ZONE_CENTER) begin
         if (r2_ff >= {23'b0, th2_ff})
            pick = (abs_lat >= abs_vert) ? lat_sec : vert_sec;
      end else if (r2_x400 < th2_x169) begin
         pick = ZONE_CENTER;
      end else if (oth_x20 > cur_x23) begin
         pick = cur_is_lat ? vert_sec : lat_sec;
      end else begin
         pick = cur_is_lat ? lat_sec : vert_sec;
      end
   end

   // tick update
   logic           open_in;
   sector_type     sector_in;
   logic [1:0]     grace_in;
   logic           capture;
   rsp_fields_type rsp_in;

   always_comb begin
      open_in   = open_ff;
      sector_in = sector_ff;
      grace_in  = (grace_ff != 2'd0) ? grace_ff - 2'd1 : 2'd0;
      capture   = 1'b0;
      rsp_in    = '0;
      if (!open_ff) begin
         if (avail_ff && held_ff && pose_ff) begin
            capture             = 1'b1;
            open_in             = 1'b1;
            sector_in           = ZONE_CENTER;
            rsp_in.opened_pulse = 1'b1;
         end
      end else if (!avail_ff) begin
         open_in   = 1'b0;
         sector_in = ZONE_CENTER;
      end else begin
         if (pose_ff && (pick != sector_ff)) begin
            sector_in            = pick;
            rsp_in.changed_pulse = 1'b1;
         end
         if (!held_ff) begin
            rsp_in.execute        = 1'b1;
            rsp_in.execute_sector = sector_in;
            open_in               = 1'b0;
            sector_in             = ZONE_CENTER;
            grace_in              = GRACE_TICKS;
         end
      end
      rsp_in.is_open      = open_in;
      rsp_in.sector       = sector_in;
      rsp_in.equip_window = (grace_in != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thresh_ff    <= PICK_THRESHOLD_RESET;
         open_ff      <= 1'b0;
         sector_ff    <= ZONE_CENTER;
         grace_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) anchor_ff[i] <= '0;
         for (int i = 0; i < 2; i++) right_ff[i] <= '0;
      end else begin
         if (csr_valid) thresh_ff <= csr_data;
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  if (open_ff && req_avail && req_pose) state_ff <= S_MX;
                  else state_ff <= S_DONE;
               end
            end
            S_MX: state_ff <= S_MZ;
            S_MZ: state_ff <= S_MT;
            S_MT: state_ff <= S_LAT;
            S_LAT: state_ff <= S_ML;
            S_ML: state_ff <= S_MV;
            S_MV: state_ff <= S_R2;
            S_R2: state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  rsp_ff       <= rsp_in;
                  open_ff      <= open_in;
                  sector_ff    <= sector_in;
                  grace_ff     <= grace_in;
                  if (capture) begin
                     for (int i = 0; i < 3; i++) anchor_ff[i] <= off_ff[i];
                     for (int i = 0; i < 2; i++) right_ff[i] <= rin_ff[i];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         held_ff  <= req_held;
         avail_ff <= req_avail;
         pose_ff  <= req_pose;
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= off_in[i];
            d_ff[i]   <= d_in[i];
         end
         for (int i = 0; i < 2; i++) rin_ff[i] <= req_right[i];
      end
      prod_ff <= mul_p;
      case (state_ff)
         S_MZ:  acc_ff <= prod_ff[42:0];
         S_MT:  acc_ff <= acc_ff + prod_ff[42:0];
         S_LAT: begin
            th2_ff <= prod_ff[31:0];
            lat_ff <= lat_in;
         end
         S_MV:  r2_ff <= prod_ff[54:0];
         S_R2:  r2_ff <= r2_ff + prod_ff[54:0];
         default: ;
      endcase
   end

   // an executed beat leaves the selector closed
   a_exec_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.execute |-> !rsp_ff.is_open)
      else $error("execute with selector still open");

   // opening always starts in center
   a_open_center: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.opened_pulse |-> rsp_ff.is_open && rsp_ff.sector == ZONE_CENTER)
      else $error("open pulse without open center state");

   // closed selector shows no sector
   a_closed_center: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> sector_ff == ZONE_CENTER)
      else $error("sector set while closed");

   // grace counter never exceeds its load value
   a_grace_range: assert property (@(posedge clock) disable iff (reset)
      grace_ff <= GRACE_TICKS)
      else $error("grace counter out of range");

   // a stalled result holds the tick update back
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !out_free |=> state_ff == S_DONE && $stable(open_ff))
      else $error("tick state moved while result stalled");

endmodule
